>>> rtl/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types and constants of the PageRank power-iteration engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pie_pkg;

  localparam int unsigned NodeMaxDefault = 1024;
  localparam int unsigned EdgeMaxDefault = 16384;

  localparam int unsigned OpW     = 3;
  localparam int unsigned NodeW   = 10;
  localparam int unsigned DegW    = 11;
  localparam int unsigned RankW   = 32;
  localparam int unsigned DampW   = 16;
  localparam int unsigned IterW   = 10;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CntW    = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned InW     = 40;
  localparam int unsigned OutW    = 80;
  localparam int unsigned EdgeW   = 2 * NodeW;
  localparam int unsigned DivW    = 33;
  localparam int unsigned DivCntW = 6;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_DEGREE = 3'd1,
    OP_EDGE   = 3'd2,
    OP_RUN    = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DAMPING = 2'd0,
    CFG_LIMIT   = 2'd1,
    CFG_NODES   = 2'd2,
    CFG_TOL     = 2'd3
  } cfg_idx_e;

  localparam logic [DampW-1:0] DampReset  = 16'd55706;
  localparam logic [IterW-1:0] LimitReset = 10'd100;
  localparam logic [CntW-1:0]  NodesReset = 11'd1024;
  localparam logic [RankW-1:0] TolReset   = 32'd429497;

endpackage
`default_nettype wire

>>> rtl/pie_ram.sv
// ----------------------------------------------------------------------------
// pie_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none
module pie_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pagerank_iteration_engine.sv
// ----------------------------------------------------------------------------
// pagerank_iteration_engine
// PageRank power iteration over a loaded graph, ranks in unsigned Q0.32.
// ----------------------------------------------------------------------------
// Clear, degree-load, edge-load and out-of-range reads finish in the cycle of
// their transfer, so loads stream one per cycle while the result side keeps
// up; a rank read passes through S_RDRANK for the rank RAM access. A run
// holds the input until it posts its result. In each pass, every stored edge
// that is in range and has a nonzero source degree costs a serial 33-step
// restoring divide by the source degree plus its RAM reads and
// read-modify-write of the destination rank; an out-of-range edge is dropped in
// S_EDSRC and a zero-degree source in S_EDMUL. The rank copy steps through
// S_CPRD and S_CPWR per node, the difference sum through S_DFRD and S_DFACC.
// Only one edge is in flight, so the destination update needs no forwarding.
`default_nettype none
module pagerank_iteration_engine #(
  parameter int unsigned MaxNodes = pie_pkg::NodeMaxDefault,
  parameter int unsigned MaxEdges = pie_pkg::EdgeMaxDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pie_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [pie_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        s_axis_tvalid_i,
  output      logic                        s_axis_tready_o,
  // op[2:0], node[12:3], neighbor[22:13], degree[33:23], zero[39:34]
  input  wire logic [pie_pkg::InW-1:0]     s_axis_tdata_i,
  output      logic                        m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // rank[31:0], iterations[41:32], final_difference[73:42], status[75:74]
  output      logic [pie_pkg::OutW-1:0]    m_axis_tdata_o
);

  import pie_pkg::*;

  localparam int unsigned NodeAw = $clog2(MaxNodes);
  localparam int unsigned EdgeAw = $clog2(MaxEdges);
  localparam int unsigned EcntW  = EdgeAw + 1;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RDRANK = 16'h0002,
    S_DIVST  = 16'h0004,
    S_DIVTP  = 16'h0008,
    S_INIT   = 16'h0010,
    S_CHECK  = 16'h0020,
    S_CPRD   = 16'h0040,
    S_CPWR   = 16'h0080,
    S_EDRD   = 16'h0100,
    S_EDSRC  = 16'h0200,
    S_EDMUL  = 16'h0400,
    S_EDDLD  = 16'h0800,
    S_EDDIV  = 16'h1000,
    S_EDACC  = 16'h2000,
    S_DFRD   = 16'h4000,
    S_DFACC  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  logic [DampW-1:0] damp_q, damp_d;
  logic [IterW-1:0] limit_q, limit_d;
  logic [CntW-1:0]  nodes_q, nodes_d;
  logic [RankW-1:0] tol_q, tol_d;

  logic [EcntW-1:0] ecnt_q, ecnt_d;
  logic [EcntW-1:0] e_q, e_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [DampW-1:0] d_q, d_d;
  logic [IterW-1:0] iters_q, iters_d;
  logic [DivW-1:0]  diff_q, diff_d;
  logic [IterW-1:0] itcnt_q, itcnt_d;
  logic [RankW-1:0] lastdiff_q, lastdiff_d;
  logic [RankW-1:0] start_q, start_d;
  logic [RankW-1:0] tele_q, tele_d;
  logic [RankW-1:0] share_q, share_d;
  logic [NodeW-1:0] dst_q, dst_d;
  logic [47:0]      prod_q, prod_d;
  logic [DegW-1:0]  den_q, den_d;
  logic [DivW-1:0]  dq_q, dq_d;
  logic [DegW-1:0]  rem_q, rem_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;

  logic             ovld_q, ovld_d;
  logic [RankW-1:0] orank_q, orank_d;
  logic [StatW-1:0] ostat_q, ostat_d;

  // input unpack
  logic [OpW-1:0]   in_op;
  logic [NodeW-1:0] in_node, in_nb;
  logic [DegW-1:0]  in_deg;
  assign in_op   = s_axis_tdata_i[2:0];
  assign in_node = s_axis_tdata_i[12:3];
  assign in_nb   = s_axis_tdata_i[22:13];
  assign in_deg  = s_axis_tdata_i[33:23];

  logic in_acc, out_acc;
  assign s_axis_tready_o = (state_q == S_IDLE) && (!ovld_q || m_axis_tready_i);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = ovld_q && m_axis_tready_i;

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {4'd0, ostat_q, lastdiff_q, itcnt_q, orank_q};

  // effective node count
  logic [31:0] nodes32, neff32;
  logic [CntW-1:0] n_eff;
  always_comb begin
    nodes32 = 32'(nodes_q);
    neff32  = nodes32;
    if (nodes32 == 32'd0) neff32 = 32'd1;
    if (nodes32 > 32'(MaxNodes)) neff32 = 32'(MaxNodes);
  end
  assign n_eff = neff32[CntW-1:0];

  // address helpers
  logic [31:0] node_x, nb_x, i_x, dst_x, src_x;
  logic [NodeW-1:0] ed_src, ed_dst;
  logic [EdgeW-1:0] edge_rdata;
  assign ed_src = edge_rdata[EdgeW-1:NodeW];
  assign ed_dst = edge_rdata[NodeW-1:0];
  assign node_x = 32'(in_node);
  assign nb_x   = 32'(in_nb);
  assign i_x    = 32'(i_q);
  assign dst_x  = 32'(dst_q);
  assign src_x  = 32'(ed_src);

  // restoring divider step
  logic [DegW:0]   rem_sh;
  logic            q_bit;
  logic [DegW-1:0] rem_nx;
  logic [DivW-1:0] dq_nx;
  logic [RankW-1:0] quo_sat;
  logic            div_last;
  always_comb begin
    rem_sh  = {rem_q, dq_q[DivW-1]};
    q_bit   = rem_sh >= {1'b0, den_q};
    rem_nx  = q_bit ? DegW'(rem_sh - {1'b0, den_q}) : rem_sh[DegW-1:0];
    dq_nx   = {dq_q[DivW-2:0], q_bit};
    quo_sat = dq_nx[DivW-1] ? '1 : dq_nx[RankW-1:0];
    div_last = dcnt_q == DivCntW'(DivW - 1);
  end

  // RAM ports
  logic              deg_we, edge_we, old_we, new_we;
  logic              deg_re, edge_re, old_re, new_re;
  logic [NodeAw-1:0] deg_waddr, deg_raddr, old_waddr, old_raddr, new_waddr, new_raddr;
  logic [EdgeAw-1:0] edge_waddr, edge_raddr;
  logic [DegW-1:0]   deg_rdata;
  logic [RankW-1:0]  old_wdata, old_rdata, new_wdata, new_rdata;

  logic [RankW-1:0] absdiff;
  logic [DivW-1:0]  diff_sum;
  logic [DivW-1:0]  acc_sum;
  assign absdiff  = (old_rdata > new_rdata) ? old_rdata - new_rdata : new_rdata - old_rdata;
  assign diff_sum = diff_q + DivW'(absdiff);
  assign acc_sum  = DivW'(new_rdata) + DivW'(share_q);

  always_comb begin
    state_d = state_q;
    damp_d = damp_q; limit_d = limit_q; nodes_d = nodes_q; tol_d = tol_q;
    ecnt_d = ecnt_q; e_d = e_q; i_d = i_q; n_d = n_q; d_d = d_q;
    iters_d = iters_q; diff_d = diff_q; itcnt_d = itcnt_q; lastdiff_d = lastdiff_q;
    start_d = start_q; tele_d = tele_q; share_d = share_q; dst_d = dst_q;
    prod_d = prod_q; den_d = den_q; dq_d = dq_q; rem_d = rem_q; dcnt_d = dcnt_q;
    ovld_d = out_acc ? 1'b0 : ovld_q;
    orank_d = orank_q; ostat_d = ostat_q;

    deg_we = 1'b0; edge_we = 1'b0; old_we = 1'b0; new_we = 1'b0;
    deg_re = 1'b0; edge_re = 1'b0; old_re = 1'b0; new_re = 1'b0;
    deg_waddr = node_x[NodeAw-1:0];
    deg_raddr = src_x[NodeAw-1:0];
    edge_waddr = ecnt_q[EdgeAw-1:0];
    edge_raddr = e_q[EdgeAw-1:0];
    old_waddr = i_x[NodeAw-1:0];
    old_raddr = i_x[NodeAw-1:0];
    old_wdata = new_rdata;
    new_waddr = i_x[NodeAw-1:0];
    new_raddr = i_x[NodeAw-1:0];
    new_wdata = start_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DAMPING: damp_d  = cfg_data_i[DampW-1:0];
        CFG_LIMIT:   limit_d = cfg_data_i[IterW-1:0];
        CFG_NODES:   nodes_d = cfg_data_i[CntW-1:0];
        CFG_TOL:     tol_d   = cfg_data_i[RankW-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          orank_d = '0;
          ostat_d = ST_OK;
          unique case (in_op)
            OP_CLEAR: begin
              ecnt_d = '0;
              ovld_d = 1'b1;
            end
            OP_DEGREE: begin
              ovld_d = 1'b1;
              if (node_x >= 32'(MaxNodes)) begin
                ostat_d = ST_RANGE;
              end else begin
                deg_we = 1'b1;
              end
            end
            OP_EDGE: begin
              ovld_d = 1'b1;
              if (node_x >= 32'(MaxNodes) || nb_x >= 32'(MaxNodes)) begin
                ostat_d = ST_RANGE;
              end else if (ecnt_q == EcntW'(MaxEdges)) begin
                ostat_d = ST_FULL;
              end else begin
                edge_we = 1'b1;
                ecnt_d  = ecnt_q + 1'b1;
              end
            end
            OP_RUN: begin
              n_d    = n_eff;
              d_d    = damp_q;
              den_d  = n_eff;
              dq_d   = {1'b1, 32'd0};
              rem_d  = '0;
              dcnt_d = '0;
              state_d = S_DIVST;
            end
            OP_READ: begin
              if (11'(in_node) >= n_eff) begin
                ostat_d = ST_RANGE;
                ovld_d  = 1'b1;
              end else begin
                new_re    = 1'b1;
                new_raddr = node_x[NodeAw-1:0];
                state_d   = S_RDRANK;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDRANK: begin
        orank_d = new_rdata;
        ovld_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_DIVST: begin
        dq_d = dq_nx; rem_d = rem_nx; dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          start_d = quo_sat;
          dq_d    = {17'(17'h10000 - {1'b0, d_q}), 16'd0};
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIVTP;
        end
      end
      S_DIVTP: begin
        dq_d = dq_nx; rem_d = rem_nx; dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          tele_d  = quo_sat;
          i_d     = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (i_q == n_q) begin
          iters_d = '0;
          diff_d  = {1'b1, 32'd0};
          state_d = S_CHECK;
        end else begin
          new_we    = 1'b1;
          new_wdata = start_q;
          i_d       = i_q + 1'b1;
        end
      end
      S_CHECK: begin
        if (iters_q < limit_q && diff_q > DivW'(tol_q)) begin
          i_d     = '0;
          state_d = S_CPRD;
        end else begin
          itcnt_d    = iters_q;
          lastdiff_d = diff_q[DivW-1] ? '1 : diff_q[RankW-1:0];
          orank_d    = '0;
          ostat_d    = ST_OK;
          ovld_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_CPRD: begin
        new_re  = 1'b1;
        state_d = S_CPWR;
      end
      S_CPWR: begin
        old_we    = 1'b1;
        old_wdata = new_rdata;
        new_we    = 1'b1;
        new_wdata = tele_q;
        i_d       = i_q + 1'b1;
        if (i_q + 1'b1 == n_q) begin
          e_d     = '0;
          state_d = S_EDRD;
        end else begin
          state_d = S_CPRD;
        end
      end
      S_EDRD: begin
        if (e_q == ecnt_q) begin
          i_d     = '0;
          diff_d  = '0;
          state_d = S_DFRD;
        end else begin
          edge_re = 1'b1;
          state_d = S_EDSRC;
        end
      end
      S_EDSRC: begin
        if (11'(ed_src) >= n_q || 11'(ed_dst) >= n_q) begin
          e_d     = e_q + 1'b1;
          state_d = S_EDRD;
        end else begin
          deg_re    = 1'b1;
          old_re    = 1'b1;
          old_raddr = src_x[NodeAw-1:0];
          dst_d     = ed_dst;
          state_d   = S_EDMUL;
        end
      end
      S_EDMUL: begin
        if (deg_rdata == '0) begin
          e_d     = e_q + 1'b1;
          state_d = S_EDRD;
        end else begin
          prod_d  = old_rdata * d_q;
          den_d   = deg_rdata;
          state_d = S_EDDLD;
        end
      end
      S_EDDLD: begin
        dq_d    = {1'b0, prod_q[47:16]};
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = S_EDDIV;
      end
      S_EDDIV: begin
        dq_d = dq_nx; rem_d = rem_nx; dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          share_d   = dq_nx[RankW-1:0];
          new_re    = 1'b1;
          new_raddr = dst_x[NodeAw-1:0];
          state_d   = S_EDACC;
        end
      end
      S_EDACC: begin
        new_we    = 1'b1;
        new_waddr = dst_x[NodeAw-1:0];
        new_wdata = acc_sum[DivW-1] ? '1 : acc_sum[RankW-1:0];
        e_d       = e_q + 1'b1;
        state_d   = S_EDRD;
      end
      S_DFRD: begin
        if (i_q == n_q) begin
          iters_d = iters_q + 1'b1;
          state_d = S_CHECK;
        end else begin
          old_re  = 1'b1;
          new_re  = 1'b1;
          state_d = S_DFACC;
        end
      end
      S_DFACC: begin
        diff_d  = diff_sum[DivW-1] ? {1'b0, 32'hFFFF_FFFF} : diff_sum;
        i_d     = i_q + 1'b1;
        state_d = S_DFRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      damp_q     <= DampReset;
      limit_q    <= LimitReset;
      nodes_q    <= NodesReset;
      tol_q      <= TolReset;
      ecnt_q     <= '0;
      itcnt_q    <= '0;
      lastdiff_q <= '0;
      ovld_q     <= 1'b0;
      e_q        <= '0;
      i_q        <= '0;
      iters_q    <= '0;
      dcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      damp_q     <= damp_d;
      limit_q    <= limit_d;
      nodes_q    <= nodes_d;
      tol_q      <= tol_d;
      ecnt_q     <= ecnt_d;
      itcnt_q    <= itcnt_d;
      lastdiff_q <= lastdiff_d;
      ovld_q     <= ovld_d;
      e_q        <= e_d;
      i_q        <= i_d;
      iters_q    <= iters_d;
      dcnt_q     <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    diff_q  <= diff_d;
    start_q <= start_d;
    tele_q  <= tele_d;
    share_q <= share_d;
    dst_q   <= dst_d;
    prod_q  <= prod_d;
    den_q   <= den_d;
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    orank_q <= orank_d;
    ostat_q <= ostat_d;
  end

  pie_ram #(.Width(DegW), .Depth(MaxNodes)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(in_deg),
    .re_i(deg_re), .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );

  pie_ram #(.Width(EdgeW), .Depth(MaxEdges)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i({in_node, in_nb}),
    .re_i(edge_re), .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  pie_ram #(.Width(RankW), .Depth(MaxNodes)) u_old_ram (
    .clk_i, .we_i(old_we), .waddr_i(old_waddr), .wdata_i(old_wdata),
    .re_i(old_re), .raddr_i(old_raddr), .rdata_o(old_rdata)
  );

  pie_ram #(.Width(RankW), .Depth(MaxNodes)) u_new_ram (
    .clk_i, .we_i(new_we), .waddr_i(new_waddr), .wdata_i(new_wdata),
    .re_i(new_re), .raddr_i(new_raddr), .rdata_o(new_rdata)
  );

`ifndef SYNTHESIS
  a_ecnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= EcntW'(MaxEdges))
    else $error("edge count beyond store depth");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == OP_RUN) |=> state_q == S_DIVST)
    else $error("run transfer did not start the sweep");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready_o)
    else $error("input taken while sweep active");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDDIV && div_last) |=> state_q == S_EDACC)
    else $error("divide did not hand over to accumulate");
`endif

endmodule
`default_nettype wire

>>> tb/sv/pagerank_checker.sv
// ----------------------------------------------------------------------------
// pagerank_checker
// Watches the configuration port and both stream channels of the PageRank
// engine, keeps its own copy of the graph, ranks and settings, predicts the
// result of each accepted command with a defined opcode, compares every result
// transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module pagerank_checker
  import pie_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [InW-1:0]     s_data_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [OutW-1:0]    m_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam longint unsigned Sat = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [IterW-1:0] iters;
    logic [RankW-1:0] diff;
    logic [StatW-1:0] status;
  } result_t;

  logic [DampW-1:0] damping;
  logic [IterW-1:0] pass_limit;
  logic [CntW-1:0]  nodes;
  logic [RankW-1:0] tol;

  logic [DegW-1:0]  degree_mem [NodeMaxDefault];
  logic [NodeW-1:0] edge_src [EdgeMaxDefault];
  logic [NodeW-1:0] edge_dst [EdgeMaxDefault];
  int unsigned      edge_cnt;
  logic [RankW-1:0] prev_rank [NodeMaxDefault];
  logic [RankW-1:0] cur_rank [NodeMaxDefault];
  logic [IterW-1:0] pass_cnt;
  logic [RankW-1:0] last_diff;

  result_t expected_results [$];
  int      errors;

  function automatic int unsigned active_nodes();
    if (nodes == 0) return 1;
    if (nodes > NodeMaxDefault) return NodeMaxDefault;
    return 32'(nodes);
  endfunction

  function automatic longint unsigned sat32(longint unsigned v);
    return (v > Sat) ? Sat : v;
  endfunction

  task automatic power_iterate();
    int unsigned       n;
    int unsigned       passes;
    int unsigned       s;
    int unsigned       d;
    longint unsigned   teleport;
    longint unsigned   diff;
    longint unsigned   share;
    longint unsigned   a;
    longint unsigned   b;
    n        = active_nodes();
    teleport = sat32(((64'd65536 - damping) << 16) / n);
    for (int i = 0; i < n; i++) cur_rank[i] = 32'(sat32((64'd1 << 32) / n));
    diff   = 64'd1 << 32;
    passes = 0;
    while (passes < pass_limit && diff > tol) begin
      for (int i = 0; i < n; i++) begin
        prev_rank[i] = cur_rank[i];
        cur_rank[i]  = 32'(teleport);
      end
      for (int e = 0; e < edge_cnt; e++) begin
        s = 32'(edge_src[e]);
        d = 32'(edge_dst[e]);
        if (s < n && d < n && degree_mem[s] != 0) begin
          share = (longint'(prev_rank[s]) * damping) / (longint'(degree_mem[s]) << 16);
          cur_rank[d] = 32'(sat32(longint'(cur_rank[d]) + share));
        end
      end
      diff = 0;
      for (int i = 0; i < n; i++) begin
        a = prev_rank[i];
        b = cur_rank[i];
        diff = sat32(diff + ((a > b) ? a - b : b - a));
      end
      passes++;
    end
    pass_cnt  = passes[IterW-1:0];
    last_diff = 32'(sat32(diff));
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t      r;
    result_t      got;
    op_e          op;
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] nb;
    if (!rst_ni) begin
      damping    = DampReset;
      pass_limit = LimitReset;
      nodes      = NodesReset;
      tol        = TolReset;
      edge_cnt   = 0;
      pass_cnt   = '0;
      last_diff  = '0;
      errors     = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DAMPING: damping    = cfg_data_i[DampW-1:0];
          CFG_LIMIT:   pass_limit = cfg_data_i[IterW-1:0];
          CFG_NODES:   nodes      = cfg_data_i[CntW-1:0];
          CFG_TOL:     tol        = cfg_data_i[RankW-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        op       = op_e'(s_data_i[2:0]);
        node     = s_data_i[12:3];
        nb       = s_data_i[22:13];
        r.rank   = '0;
        r.status = ST_OK;
        case (op)
          OP_CLEAR:  edge_cnt = 0;
          OP_DEGREE: degree_mem[node] = s_data_i[33:23];
          OP_EDGE: begin
            if (edge_cnt >= EdgeMaxDefault) begin
              r.status = ST_FULL;
            end else begin
              edge_src[edge_cnt] = node;
              edge_dst[edge_cnt] = nb;
              edge_cnt++;
            end
          end
          OP_RUN:  power_iterate();
          OP_READ: begin
            if (node >= active_nodes()) r.status = ST_RANGE;
            else r.rank = cur_rank[node];
          end
          default: ;
        endcase
        r.iters = pass_cnt;
        r.diff  = last_diff;
        if (s_data_i[2:0] <= OP_READ) expected_results.push_back(r);
      end
      if (m_valid_i && m_ready_i) begin
        got = {m_data_i[31:0], m_data_i[41:32], m_data_i[73:42], m_data_i[75:74]};
        if (expected_results.size() == 0) begin
          report("unexpected result rank", got.rank, 0);
        end else begin
          r = expected_results.pop_front();
          if (got.rank != r.rank) report("rank", got.rank, r.rank);
          if (got.iters != r.iters) report("iterations", got.iters, r.iters);
          if (got.diff != r.diff) report("final_difference", got.diff, r.diff);
          if (got.status != r.status) report("status", got.status, r.status);
        end
      end
    end
    errors_o  <= errors;
    pending_o <= expected_results.size();
  end

endmodule

>>> tb/sv/tb_pagerank_iteration_engine.sv
// ----------------------------------------------------------------------------
// tb_pagerank_iteration_engine
// Stimulus for the PageRank engine: a directed part covering extreme settings,
// range errors and ignored commands, then random phases of graph loads, runs
// and rank reads under several settings, with random gaps on both stream
// sides. Checking is done by pagerank_checker.
// ----------------------------------------------------------------------------
module tb_pagerank_iteration_engine;
  import pie_pkg::*;

  localparam int IdleLimit = 600000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  logic               s_valid;
  logic               s_ready;
  logic [InW-1:0]     s_data;
  logic               m_valid;
  logic               m_ready;
  logic [OutW-1:0]    m_data;
  int                 errors;
  int                 pending;
  bit                 quiet;
  int                 idle_cycles;
  int                 stall;
  int unsigned        n_cur;
  int unsigned        e_cnt;

  pagerank_iteration_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  pagerank_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_valid_i  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_i   (s_data),
    .m_valid_i  (m_valid),
    .m_ready_i  (m_ready),
    .m_data_i   (m_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      stall   = 0;
    end else if (stall > 0) begin
      stall--;
      m_ready <= 1'b0;
    end else begin
      stall = pick_gap();
      m_ready <= (stall == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [InW-1:0] pack_cmd(logic [OpW-1:0] op, logic [NodeW-1:0] node,
                                              logic [NodeW-1:0] nb, logic [DegW-1:0] deg);
    return {6'b0, deg, nb, node, op};
  endfunction

  task automatic send(logic [OpW-1:0] op, logic [NodeW-1:0] node,
                      logic [NodeW-1:0] nb, logic [DegW-1:0] deg);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= pack_cmd(op, node, nb, deg);
    do @(posedge clk_i); while (!s_ready);
    if (op == OP_CLEAR) e_cnt = 0;
    if (op == OP_EDGE) e_cnt++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(logic [DampW-1:0] d, logic [IterW-1:0] l,
                           logic [CntW-1:0] n, logic [RankW-1:0] t);
    drain();
    cfg_we <= 1'b1; cfg_idx <= CFG_DAMPING; cfg_data <= d; @(posedge clk_i);
    cfg_idx <= CFG_LIMIT; cfg_data <= l; @(posedge clk_i);
    cfg_idx <= CFG_NODES; cfg_data <= n; @(posedge clk_i);
    cfg_idx <= CFG_TOL;   cfg_data <= t; @(posedge clk_i);
    cfg_we <= 1'b0;
    n_cur = (n == 0) ? 1 : (n > NodeMaxDefault) ? NodeMaxDefault : n;
  endtask

  // nodes 0..31 and 1023 carry loaded degrees
  function automatic logic [NodeW-1:0] pick_node();
    int unsigned lim;
    lim = (n_cur < 32) ? n_cur : 32;
    if ($urandom_range(0, 9) < 8) return NodeW'($urandom_range(0, lim - 1));
    if ($urandom_range(0, 1) == 0) return NodeW'(NodeMaxDefault - 1);
    return NodeW'($urandom_range(0, 31));
  endfunction

  initial begin
    int r;
    logic [DampW-1:0] d;
    logic [RankW-1:0] t;
    logic [CntW-1:0]  n;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    s_valid  = 1'b0;
    s_data   = '0;
    quiet    = 1'b0;
    n_cur    = NodeMaxDefault;
    e_cnt    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, no edges: writes every rank
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 1023, 0, 0);
    quiet = 1'b1;
    for (int i = 0; i < 32; i++)
      send(OP_DEGREE, NodeW'(i), 0, (i == 0) ? 11'd0 : 11'($urandom_range(1, 4)));
    send(OP_DEGREE, 1023, 0, 11'd1024);
    quiet = 1'b0;

    configure(16'hFFFF, 10'd1023, 11'd2, 32'd0);
    send(OP_DEGREE, 1, 0, 2);
    send(OP_EDGE, 1, 0, 0);
    send(OP_EDGE, 1, 1, 0);
    send(OP_EDGE, 0, 1, 0);
    send(OP_EDGE, 1023, 0, 0);
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 1, 0, 0);
    send(OP_READ, 2, 0, 0);
    send(3'd5, 1023, 1023, 2047);
    send(3'd6, 0, 0, 0);
    send(3'd7, 5, 5, 5);

    configure(16'd0, 10'd0, 11'd0, 32'hFFFF_FFFF);
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_READ, 1, 0, 0);

    configure(DampReset, 10'd1, 11'd2047, 32'hFFFF_FFFF);
    send(OP_RUN, 0, 0, 0);
    send(OP_READ, 1023, 0, 0);

    for (int ph = 0; ph < 7; ph++) begin
      r = $urandom_range(0, 2);
      d = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
      r = $urandom_range(0, 3);
      t = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? 32'($urandom_range(0, 5000000))
                                                                   : 32'($urandom);
      n = (ph == 3) ? 11'd1024 : 11'($urandom_range(1, 16));
      configure(d, (ph == 3) ? 10'd2 : 10'($urandom_range(0, 8)), n, t);
      send(OP_CLEAR, 0, 0, 0);
      quiet = (ph == 5);
      for (int k = 0; k < 85; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          send(OP_DEGREE, pick_node(), 10'($urandom),
               ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 1024))
                                           : 11'($urandom_range(0, 4)));
        end else if (r < 55) begin
          if (e_cnt >= 12) send(OP_CLEAR, 10'($urandom), 10'($urandom), 11'($urandom));
          else send(OP_EDGE, pick_node(), pick_node(), 11'($urandom));
        end else if (r < 82) begin
          send(OP_READ, pick_node(), 10'($urandom), 11'($urandom));
        end else if (r < 89) begin
          send(OP_RUN, 10'($urandom), 10'($urandom), 11'($urandom));
        end else if (r < 92) begin
          send(OP_CLEAR, 10'($urandom), 10'($urandom), 11'($urandom));
        end else if (r < 95) begin
          send(3'($urandom_range(5, 7)), 10'($urandom), 10'($urandom), 11'($urandom));
        end else begin
          send(OP_RUN, 0, 0, 0);
          send(OP_READ, pick_node(), 0, 0);
        end
      end
      quiet = 1'b0;
    end

    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pie_pkg.sv
rtl/pie_ram.sv
rtl/pagerank_iteration_engine.sv
tb/sv/pagerank_checker.sv
tb/sv/tb_pagerank_iteration_engine.sv
